[hw/rtl/regex_pattern_cost_parser_assert.svh]
// Assertion helpers shared by the RTL.
`ifndef REGEX_PATTERN_COST_PARSER_ASSERT_SVH
`define REGEX_PATTERN_COST_PARSER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define RPC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define RPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hw/rtl/rpc_pkg.sv]
package rpc_pkg;

   localparam int CNT_W = 41;
   localparam int BND_W = 30;
   localparam int CPY_W = 31;

   localparam logic [CNT_W-1:0] SAT_COUNT = 41'h100_0000_0000;

   typedef logic [CNT_W-1:0] count_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_SYNTAX  = 2'd1,
      ST_BOUND   = 2'd2,
      ST_NESTING = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      M_NORMAL, M_LAZY, M_GP0, M_GP1, M_GPFLAG, M_GPLT, M_GPNAME,
      M_CL0, M_CL1, M_CLBODY, M_ESC, M_ESC_P, M_ESC_C, M_HEXF, M_HEX,
      M_BRACE_P, M_BRACE_X, M_REP_A, M_REP_LO, M_REP_B, M_REP_C, M_REP_HI, M_REP_D
   } mode_type;

   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LBRK   = 8'h5B;
   localparam logic [7:0] CH_RBRK   = 8'h5D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_BSL    = 8'h5C;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_DASH   = 8'h2D;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   function automatic logic is_flag(logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_DASH);
   endfunction

   function automatic logic is_class_esc(logic [7:0] c);
      return (c == 8'h64) || (c == 8'h44) || (c == 8'h77) || (c == 8'h57) ||
             (c == 8'h73) || (c == 8'h53);
   endfunction

   function automatic count_type sat_add(count_type a, count_type b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, SAT_COUNT}) ? SAT_COUNT : s[CNT_W-1:0];
   endfunction

   function automatic count_type sat_mul(count_type a, logic [CPY_W-1:0] b);
      logic [CNT_W+CPY_W-1:0] p;
      p = {{CPY_W{1'b0}}, a} * {{CNT_W{1'b0}}, b};
      return (p > {{CPY_W{1'b0}}, SAT_COUNT}) ? SAT_COUNT : p[CNT_W-1:0];
   endfunction

endpackage

[hw/rtl/rpc_ram.sv]
module rpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/regex_pattern_cost_parser.sv]
// Pattern cost parser: takes a regular-expression pattern one byte per transfer on req_
// (req_tlast marks the end item, whose byte is ignored) and, for each end item, sends one
// rsp_ transfer carrying the class-atom count, the literal-atom count (both saturated at
// 2^40) and a status. A new byte may follow in each cycle unless the output register is full
// and not being taken; the limit is the saturating multiply-add that folds a pending atom
// into the current group's totals. Totals of enclosing groups live in a small RAM
// (one entry per open group); the innermost group's totals stay in registers and the
// parent entry is prefetched, with a write bypass for a push that is followed directly
// by a pop. No clearing pass is needed after reset. The result sits in an output
// register; the input stalls only when that register is full and not being taken.
module regex_pattern_cost_parser #(
   parameter int MAX_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   // pattern stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,     // [7:0] symbol
   input  logic         req_tlast,     // is_end
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,     // [40:0] class_count, [81:41] literal_count,
                                       // [83:82] status, [87:84] zero
   // register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import rpc_pkg::*;

   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   // register file: repeat_limit only
   logic [BND_W-1:0] limit_ff;

   // parse state
   mode_type         mode_ff;
   logic [DW-1:0]    depth_ff;
   count_type        cur_c_ff, cur_l_ff;      // innermost group totals
   count_type        pc_ff, pl_ff;            // pending atom
   logic             pv_ff;
   logic [BND_W-1:0] lo_ff, hi_ff;
   logic [3:0]       dg_ff;
   logic [2:0]       hx_ff;
   logic             incls_ff;
   status_type       err_ff;

   // parent totals bypass
   logic                 fwd_ff;
   logic [2*CNT_W-1:0]   fwd_data_ff;

   logic                 rsp_valid_ff;
   logic [87:0]          rsp_data_ff;

   logic                 accept;
   logic [7:0]           c;

   // step results
   mode_type         m;
   logic             pv, incls, cm_en, push, pop, busy;
   count_type        pc, pl, cm_c, cm_l;
   logic [BND_W-1:0] lo, hi, bnd;
   logic [3:0]       dg;
   logic [2:0]       hx;
   status_type       err;
   logic [CPY_W-1:0] cm_cnt;

   count_type        cur_c_after, cur_l_after, par_c, par_l;
   logic [2*CNT_W-1:0] ram_rdata, ram_wdata;
   logic             ram_we;
   logic [DW-1:0]    depth_in, rd_addr;
   status_type       final_err;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign c          = req_tdata;

   // one pattern byte, or the end item; chained modes resolve in up to four passes
   always_comb begin
      m      = mode_ff;
      pv     = pv_ff;
      pc     = pc_ff;
      pl     = pl_ff;
      lo     = lo_ff;
      hi     = hi_ff;
      dg     = dg_ff;
      hx     = hx_ff;
      incls  = incls_ff;
      err    = ST_OK;
      cm_en  = 1'b0;
      cm_cnt = '0;
      cm_c   = pc_ff;
      cm_l   = pl_ff;
      push   = 1'b0;
      pop    = 1'b0;
      busy   = 1'b1;
      bnd    = '0;
      if (!req_tlast) begin
         for (int p = 0; p < 4; p++) begin
            if (busy) begin
               busy = 1'b0;
               unique case (m)
                  M_NORMAL: begin
                     if (pv && (c == CH_STAR || c == CH_PLUS || c == CH_QUEST)) begin
                        cm_en = 1'b1; cm_cnt = CPY_W'(1); cm_c = pc; cm_l = pl;
                        pc = '0; pl = '0; pv = 1'b0; m = M_LAZY;
                     end else if (pv && c == CH_LBRACE) begin
                        lo = '0; hi = '0; dg = '0; m = M_REP_A;
                     end else begin
                        if (pv) begin
                           cm_en = 1'b1; cm_cnt = CPY_W'(1); cm_c = pc; cm_l = pl;
                           pc = '0; pl = '0; pv = 1'b0;
                        end
                        priority case (c)
                           CH_RPAR: begin
                              if (depth_ff == '0) err = ST_SYNTAX;
                              else begin
                                 pop = 1'b1; pv = 1'b1; m = M_NORMAL;
                              end
                           end
                           CH_BAR, CH_CARET, CH_DOLLAR: ;
                           CH_LPAR: begin
                              if (depth_ff >= DW'(MAX_DEPTH)) err = ST_NESTING;
                              else begin
                                 push = 1'b1; m = M_GP0;
                              end
                           end
                           CH_LBRK: m = M_CL0;
                           CH_DOT: begin
                              pc = CNT_W'(1); pl = '0; pv = 1'b1; m = M_NORMAL;
                           end
                           CH_BSL: begin
                              incls = 1'b0; m = M_ESC;
                           end
                           CH_STAR, CH_PLUS, CH_QUEST, CH_LBRACE: err = ST_SYNTAX;
                           default: begin
                              pc = '0; pl = CNT_W'(1); pv = 1'b1; m = M_NORMAL;
                           end
                        endcase
                     end
                  end
                  M_LAZY: begin
                     m = M_NORMAL;
                     if (!(c == CH_QUEST || c == CH_PLUS)) busy = 1'b1;
                  end
                  M_GP0: begin
                     if (c == CH_QUEST) m = M_GP1;
                     else begin
                        m = M_NORMAL; busy = 1'b1;
                     end
                  end
                  M_GP1: begin
                     if (c == CH_LT) m = M_GPLT;
                     else begin
                        m = M_GPFLAG; busy = 1'b1;
                     end
                  end
                  M_GPFLAG: begin
                     if (!is_flag(c)) begin
                        m = M_NORMAL;
                        if (!(c == CH_COLON || c == CH_EQ || c == CH_BANG)) busy = 1'b1;
                     end
                  end
                  M_GPLT: m = (c == CH_EQ || c == CH_BANG || c == CH_GT) ? M_NORMAL : M_GPNAME;
                  M_GPNAME: if (c == CH_GT) m = M_NORMAL;
                  M_CL0: begin
                     m = M_CL1;
                     if (c != CH_CARET) busy = 1'b1;
                  end
                  M_CL1: begin
                     m = M_CLBODY;
                     if (c != CH_RBRK) busy = 1'b1;
                  end
                  M_CLBODY: begin
                     if (c == CH_RBRK) begin
                        pc = CNT_W'(1); pl = '0; pv = 1'b1; m = M_NORMAL;
                     end else if (c == CH_BSL) begin
                        incls = 1'b1; m = M_ESC;
                     end
                  end
                  M_ESC: begin
                     if (is_class_esc(c)) begin
                        if (incls) begin
                           incls = 1'b0; m = M_CLBODY;
                        end else begin
                           pc = CNT_W'(1); pl = '0; pv = 1'b1; m = M_NORMAL;
                        end
                     end else if (c == 8'h70 || c == 8'h50) m = M_ESC_P;
                     else if (c == 8'h78) begin
                        hx = 3'd2; m = M_HEXF;
                     end else if (c == 8'h75) begin
                        hx = 3'd4; m = M_HEXF;
                     end else if (c == 8'h63) m = M_ESC_C;
                     else if (incls) begin
                        incls = 1'b0; m = M_CLBODY;
                     end else begin
                        pc = '0; pl = CNT_W'(1); pv = 1'b1; m = M_NORMAL;
                     end
                  end
                  M_ESC_P: begin
                     if (c == CH_LBRACE) m = M_BRACE_P;
                     else if (incls) begin
                        incls = 1'b0; m = M_CLBODY;
                     end else begin
                        pc = CNT_W'(1); pl = '0; pv = 1'b1; m = M_NORMAL;
                     end
                  end
                  M_ESC_C: begin
                     if (incls) begin
                        incls = 1'b0; m = M_CLBODY;
                     end else begin
                        pc = '0; pl = CNT_W'(1); pv = 1'b1; m = M_NORMAL;
                     end
                  end
                  M_HEXF: begin
                     if (c == CH_LBRACE) m = M_BRACE_X;
                     else begin
                        m = M_HEX; busy = 1'b1;
                     end
                  end
                  M_HEX: begin
                     if (hx != '0 && is_hex(c)) begin
                        hx = hx - 3'd1;
                        if (hx == '0) begin
                           if (incls) begin
                              incls = 1'b0; m = M_CLBODY;
                           end else begin
                              pc = '0; pl = CNT_W'(1); pv = 1'b1; m = M_NORMAL;
                           end
                        end
                     end else begin
                        hx = '0;
                        busy = 1'b1;
                        if (incls) begin
                           incls = 1'b0; m = M_CLBODY;
                        end else begin
                           pc = '0; pl = CNT_W'(1); pv = 1'b1; m = M_NORMAL;
                        end
                     end
                  end
                  M_BRACE_P: begin
                     if (c == CH_RBRACE) begin
                        if (incls) begin
                           incls = 1'b0; m = M_CLBODY;
                        end else begin
                           pc = CNT_W'(1); pl = '0; pv = 1'b1; m = M_NORMAL;
                        end
                     end
                  end
                  M_BRACE_X: begin
                     if (c == CH_RBRACE) begin
                        if (incls) begin
                           incls = 1'b0; m = M_CLBODY;
                        end else begin
                           pc = '0; pl = CNT_W'(1); pv = 1'b1; m = M_NORMAL;
                        end
                     end
                  end
                  M_REP_A: begin
                     if (is_digit(c)) begin
                        lo = BND_W'(c[3:0]); dg = 4'd1; m = M_REP_LO;
                     end else if (c != CH_SPACE) err = ST_SYNTAX;
                  end
                  M_REP_LO: begin
                     if (is_digit(c)) begin
                        if (dg == 4'd9) err = ST_SYNTAX;
                        else begin
                           dg = dg + 4'd1;
                           lo = (lo << 3) + (lo << 1) + BND_W'(c[3:0]);
                        end
                     end else begin
                        m = M_REP_B;
                        if (c != CH_SPACE) busy = 1'b1;
                     end
                  end
                  M_REP_B: begin
                     if (c == CH_RBRACE) begin
                        bnd = lo;
                        if (lo > limit_ff) err = ST_BOUND;
                        else begin
                           cm_en = 1'b1; cm_cnt = CPY_W'(lo); cm_c = pc; cm_l = pl;
                           pc = '0; pl = '0; pv = 1'b0; m = M_LAZY;
                        end
                     end else if (c == CH_COMMA) m = M_REP_C;
                     else if (c != CH_SPACE) err = ST_SYNTAX;
                  end
                  M_REP_C: begin
                     if (c == CH_RBRACE) begin
                        bnd = lo;
                        if (lo > limit_ff) err = ST_BOUND;
                        else begin
                           cm_en = 1'b1; cm_cnt = CPY_W'(lo) + CPY_W'(1); cm_c = pc;
                           cm_l = pl; pc = '0; pl = '0; pv = 1'b0; m = M_LAZY;
                        end
                     end else if (is_digit(c)) begin
                        hi = BND_W'(c[3:0]); dg = 4'd1; m = M_REP_HI;
                     end else if (c != CH_SPACE) err = ST_SYNTAX;
                  end
                  M_REP_HI: begin
                     if (is_digit(c)) begin
                        if (dg == 4'd9) err = ST_SYNTAX;
                        else begin
                           dg = dg + 4'd1;
                           hi = (hi << 3) + (hi << 1) + BND_W'(c[3:0]);
                        end
                     end else if (hi < lo) err = ST_SYNTAX;
                     else begin
                        m = M_REP_D; busy = 1'b1;
                     end
                  end
                  M_REP_D: begin
                     if (c == CH_RBRACE) begin
                        bnd = hi;
                        if (hi > limit_ff) err = ST_BOUND;
                        else begin
                           cm_en = 1'b1; cm_cnt = CPY_W'(hi); cm_c = pc; cm_l = pl;
                           pc = '0; pl = '0; pv = 1'b0; m = M_LAZY;
                        end
                     end else if (c != CH_SPACE) err = ST_SYNTAX;
                  end
                  default: err = ST_SYNTAX;
               endcase
            end
         end
      end else begin
         // end item: close out a pending atom or an optional escape tail
         unique case (mode_ff)
            M_NORMAL: begin
               if (pv_ff) begin
                  cm_en = 1'b1; cm_cnt = CPY_W'(1);
               end
            end
            M_LAZY, M_GP0, M_GP1, M_GPFLAG: ;
            M_ESC_P: begin
               if (incls_ff) err = ST_SYNTAX;
               else begin
                  cm_en = 1'b1; cm_cnt = CPY_W'(1); cm_c = CNT_W'(1); cm_l = '0;
               end
            end
            M_ESC_C, M_HEXF, M_HEX: begin
               if (incls_ff) err = ST_SYNTAX;
               else begin
                  cm_en = 1'b1; cm_cnt = CPY_W'(1); cm_c = '0; cm_l = CNT_W'(1);
               end
            end
            default: err = ST_SYNTAX;
         endcase
         if (err == ST_OK && depth_ff != '0) err = ST_SYNTAX;
      end
   end

   // fold the committed atom into the innermost totals
   always_comb begin
      cur_c_after = cur_c_ff;
      cur_l_after = cur_l_ff;
      if (cm_en) begin
         cur_c_after = sat_add(cur_c_ff, sat_mul(cm_c, cm_cnt));
         cur_l_after = sat_add(cur_l_ff, sat_mul(cm_l, cm_cnt));
      end
   end

   assign final_err = (err_ff != ST_OK) ? err_ff : err;

   // enclosing-group totals
   assign ram_we    = accept && !req_tlast && (err_ff == ST_OK) && push;
   assign ram_wdata = {cur_l_after, cur_c_after};

   always_comb begin
      depth_in = depth_ff;
      if (accept) begin
         if (req_tlast) depth_in = '0;
         else if (err_ff == ST_OK && push) depth_in = depth_ff + DW'(1);
         else if (err_ff == ST_OK && pop) depth_in = depth_ff - DW'(1);
      end
      rd_addr = (depth_in == '0) ? '0 : depth_in - DW'(1);
   end

   rpc_ram #(
      .WIDTH (2 * CNT_W),
      .DEPTH (MAX_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (depth_ff[AW-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (rd_addr[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign {par_l, par_c} = fwd_ff ? fwd_data_ff : ram_rdata;

   always_ff @(posedge clock) begin
      fwd_data_ff <= ram_wdata;
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= ram_we && (depth_ff == rd_addr);
      end
   end

   // parse state update
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_NORMAL;
         depth_ff <= '0;
         cur_c_ff <= '0;
         cur_l_ff <= '0;
         pc_ff    <= '0;
         pl_ff    <= '0;
         pv_ff    <= 1'b0;
         lo_ff    <= '0;
         hi_ff    <= '0;
         dg_ff    <= '0;
         hx_ff    <= '0;
         incls_ff <= 1'b0;
         err_ff   <= ST_OK;
      end else if (accept) begin
         if (req_tlast) begin
            mode_ff  <= M_NORMAL;
            depth_ff <= '0;
            cur_c_ff <= '0;
            cur_l_ff <= '0;
            pc_ff    <= '0;
            pl_ff    <= '0;
            pv_ff    <= 1'b0;
            lo_ff    <= '0;
            hi_ff    <= '0;
            dg_ff    <= '0;
            hx_ff    <= '0;
            incls_ff <= 1'b0;
            err_ff   <= ST_OK;
         end else if (err_ff == ST_OK) begin
            err_ff   <= err;
            mode_ff  <= m;
            depth_ff <= depth_in;
            lo_ff    <= lo;
            hi_ff    <= hi;
            dg_ff    <= dg;
            hx_ff    <= hx;
            incls_ff <= incls;
            pv_ff    <= pv;
            if (push) begin
               cur_c_ff <= '0;
               cur_l_ff <= '0;
            end else if (pop) begin
               cur_c_ff <= par_c;
               cur_l_ff <= par_l;
            end else begin
               cur_c_ff <= cur_c_after;
               cur_l_ff <= cur_l_after;
            end
            if (pop) begin
               pc_ff <= cur_c_after;
               pl_ff <= cur_l_after;
            end else begin
               pc_ff <= pc;
               pl_ff <= pl;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (accept && req_tlast) begin
         rsp_data_ff <= {4'b0, final_err,
                         (final_err == ST_OK) ? cur_l_after : count_type'(0),
                         (final_err == ST_OK) ? cur_c_after : count_type'(0)};
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_tlast) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // register port: repeat_limit at byte address 0
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= BND_W'(1000);
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         limit_ff <= csr_pwdata[BND_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'b0 : {2'b0, limit_ff};

   // bound compared against the limit on this byte
   logic bound_over;
   assign bound_over = (bnd > limit_ff);

   `include "regex_pattern_cost_parser_assert.svh"

   `RPC_ASSERT_ALWAYS(a_depth_range, clock, reset, depth_ff <= DW'(MAX_DEPTH))
   `RPC_ASSERT_ALWAYS(a_err_zero_counts, clock, reset, !rsp_valid_ff || rsp_data_ff[83:82] == ST_OK || rsp_data_ff[81:0] == '0)
   `RPC_ASSERT_NEXT(a_end_result, clock, reset, accept && req_tlast, rsp_valid_ff && depth_ff == '0 && err_ff == ST_OK)
   `RPC_ASSERT_ALWAYS(a_bound_err, clock, reset, !(accept && !req_tlast && err == ST_BOUND) || bound_over)
endmodule
